// ----- rtl/gei_pkg.sv -----
// Shared types and constants for the gain envelope interpolator.
// Used by the core, the checker and the testbench; no dependencies.
package gei_pkg;

  localparam int unsigned MAX_MARKS_DEF = 16;
  localparam int unsigned POS_DIV_DEF   = 2;

  localparam int unsigned TIME_W  = 31;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned MRG_W   = 7;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_W   = 2;
  // (now - prev) * 100 fits 38 bits, |mag| * frac fits 45 bits
  localparam int unsigned FRAC_W  = 38;
  localparam int unsigned PROD_W  = 45;
  localparam int unsigned PCT_W   = 7;
  localparam logic [PCT_W-1:0] PERCENT = 7'd100;

  typedef enum logic [CFG_W-1:0] {
    CFG_MARK_COUNT = 2'd0,
    CFG_CLIP_DUR   = 2'd1,
    CFG_MARGIN     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // side information carried past the fraction divider
  typedef struct packed {
    logic signed [LVL_W-1:0] prev_lvl;
    logic [LVL_W-1:0]        abs_mag;
    logic                    mag_neg;
    logic                    diff_neg;
    logic                    span_zero;
    logic                    span_pos;
  } frac_side_t;

  // side information carried past the divide by one hundred
  typedef struct packed {
    logic signed [LVL_W-1:0] prev_lvl;
    logic                    inc_neg;
    logic                    diff_neg;
    logic                    span_zero;
  } inc_side_t;

endpackage

// ----- rtl/gain_envelope_interpolator_core.sv -----
// Gain envelope interpolator: mark table, interval select, pipelined fraction divider
// and a reciprocal divide by one hundred.
// A query's result leaves through the output register at the end of the pipeline; one item
// per cycle, limited by nothing but the output stall, which holds the whole pipeline.
// Mark writes take effect at their transfer and give no result.
// Reset clears the configuration registers and the pipeline valid bits; the table is
// undefined until written.
module gain_envelope_interpolator_core #(
  parameter int unsigned MAX_MARKS        = gei_pkg::MAX_MARKS_DEF,
  parameter int unsigned POSITIVE_DIVIDER = gei_pkg::POS_DIV_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gei_pkg::CFG_W-1:0]         cfg_index_i,
  input  logic [gei_pkg::TIME_W-1:0]        cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [gei_pkg::IDX_W-1:0]         mark_index_i,
  input  logic [gei_pkg::TIME_W-1:0]        mark_time_ms_i,
  input  logic signed [gei_pkg::LVL_W-1:0]  mark_level_i,
  input  logic [gei_pkg::TIME_W-1:0]        query_time_ms_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [gei_pkg::LVL_W-1:0]  envelope_gain_o,
  output logic signed [gei_pkg::LVL_W-1:0]  total_gain_o,
  output logic                              apply_gain_o
);

  localparam int unsigned TW   = gei_pkg::TIME_W;
  localparam int unsigned LW   = gei_pkg::LVL_W;
  localparam int unsigned AW   = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int unsigned NW   = $clog2(MAX_MARKS + 1) + 1;
  localparam int unsigned FW   = gei_pkg::FRAC_W;
  localparam int unsigned PW   = gei_pkg::PROD_W;
  localparam int unsigned F1SW = $bits(gei_pkg::frac_side_t);
  // divide by one hundred in three 15-bit digits; partial remainder joins each digit
  localparam int unsigned CW   = 15;
  localparam int unsigned RW   = 22;
  localparam logic [22:0] RECIP100 = 23'd5368710;  // ceil(2^29 / 100)

  logic en;
  logic in_xfer;

  // whole pipeline moves when the output slot is free or being emptied
  logic out_vld_q;
  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign in_xfer     = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  logic [gei_pkg::CNT_W-1:0] mark_count_q;
  logic [TW-1:0]             clip_dur_q;
  logic [gei_pkg::MRG_W-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_count_q <= '0;
      clip_dur_q   <= '0;
      margin_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (gei_pkg::cfg_idx_e'(cfg_index_i))
        gei_pkg::CFG_MARK_COUNT: mark_count_q <= cfg_data_i[gei_pkg::CNT_W-1:0];
        gei_pkg::CFG_CLIP_DUR:   clip_dur_q   <= cfg_data_i;
        gei_pkg::CFG_MARGIN:     margin_q     <= cfg_data_i[gei_pkg::MRG_W-1:0];
        default: ;
      endcase
    end
  end

  // mark table, written at the transfer of a write item
  logic [TW-1:0] mark_times_q  [MAX_MARKS];
  logic [LW-1:0] mark_levels_q [MAX_MARKS];
  logic [8:0]    wr_slot;

  assign wr_slot = 9'(mark_index_i);

  always_ff @(posedge clk_i) begin
    if (in_xfer && (gei_pkg::op_e'(operation_i) == gei_pkg::OP_WRITE)
        && (32'(wr_slot) < MAX_MARKS)) begin
      mark_times_q[wr_slot[AW-1:0]]  <= mark_time_ms_i;
      mark_levels_q[wr_slot[AW-1:0]] <= mark_level_i;
    end
  end

  // positive level divide table
  logic [6:0] pos_lut [128];
  for (genvar g = 0; g < 128; g++) begin : g_lut
    localparam logic [6:0] LutVal = 7'(g / POSITIVE_DIVIDER);
    assign pos_lut[g] = LutVal;
  end

  // stage 0: query capture
  logic          s0_vld_q;
  logic [TW-1:0] s0_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_xfer && (gei_pkg::op_e'(operation_i) == gei_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_now_q <= query_time_ms_i;
    end
  end

  // stage 1: find the marks around the query time
  logic [NW-1:0]        n_eff;
  logic [MAX_MARKS-1:0] inr, gt, prev_sel, next_sel;
  logic [MAX_MARKS:0]   nogt;
  logic [TW-1:0]        prev_t, next_t;
  logic [LW-1:0]        prev_raw, next_raw;
  logic                 any_prev, any_next;

  always_comb begin
    n_eff = (32'(mark_count_q) > MAX_MARKS) ? NW'(MAX_MARKS) : NW'(mark_count_q);
    for (int i = 0; i < MAX_MARKS; i++) begin
      inr[i] = 32'(i) < 32'(n_eff);
      gt[i]  = inr[i] && (mark_times_q[i] > s0_now_q);
    end
    nogt[0] = 1'b1;
    for (int i = 0; i < MAX_MARKS; i++) begin
      nogt[i+1] = nogt[i] && !gt[i];
    end
    for (int i = 0; i < MAX_MARKS; i++) begin
      next_sel[i] = gt[i] && nogt[i];
      if (i == MAX_MARKS - 1) begin
        prev_sel[i] = inr[i] && nogt[i+1];
      end else begin
        prev_sel[i] = inr[i] && nogt[i+1] && (!inr[i+1] || gt[i+1]);
      end
    end
    prev_t   = '0;
    next_t   = '0;
    prev_raw = '0;
    next_raw = '0;
    for (int i = 0; i < MAX_MARKS; i++) begin
      prev_t   = prev_t   | (mark_times_q[i]  & {TW{prev_sel[i]}});
      next_t   = next_t   | (mark_times_q[i]  & {TW{next_sel[i]}});
      prev_raw = prev_raw | (mark_levels_q[i] & {LW{prev_sel[i]}});
      next_raw = next_raw | (mark_levels_q[i] & {LW{next_sel[i]}});
    end
    any_prev = |prev_sel;
    any_next = |next_sel;
  end

  function automatic logic signed [LW-1:0] level_of(input logic [LW-1:0] raw,
                                                    input logic [6:0]    lut);
    logic signed [LW-1:0] v;
    v = raw;
    level_of = (!v[LW-1] && (v != '0)) ? LW'(lut) : v;
  endfunction

  logic                 s1_vld_q;
  logic [TW-1:0]        s1_now_q, s1_prev_t_q, s1_next_t_q;
  logic signed [LW-1:0] s1_prev_l_q, s1_next_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_now_q    <= s0_now_q;
      s1_prev_t_q <= any_prev ? prev_t : '0;
      s1_next_t_q <= any_next ? next_t : clip_dur_q;
      s1_prev_l_q <= any_prev ? level_of(prev_raw, pos_lut[prev_raw[6:0]]) : '0;
      s1_next_l_q <= any_next ? level_of(next_raw, pos_lut[next_raw[6:0]]) : '0;
    end
  end

  // stage 2: span, scaled offset and level step
  logic signed [TW:0]   span;
  logic [TW-1:0]        t_off;
  logic signed [LW:0]   diff;
  logic [LW:0]          abs_diff;
  logic [LW-1:0]        mag8, abs_mag;
  gei_pkg::frac_side_t  s2_side;

  always_comb begin
    span     = $signed({1'b0, s1_next_t_q}) - $signed({1'b0, s1_prev_t_q});
    t_off    = s1_now_q - s1_prev_t_q;
    diff     = (LW+1)'(s1_next_l_q) - (LW+1)'(s1_prev_l_q);
    abs_diff = diff[LW] ? (LW+1)'(-diff) : (LW+1)'(diff);
    mag8     = abs_diff[LW-1:0];
    abs_mag  = mag8[LW-1] ? LW'(-mag8) : mag8;
    s2_side.prev_lvl  = s1_prev_l_q;
    s2_side.abs_mag   = abs_mag;
    s2_side.mag_neg   = mag8[LW-1];
    s2_side.diff_neg  = diff[LW];
    s2_side.span_zero = (span == '0);
    s2_side.span_pos  = !span[TW] && (span != '0);
  end

  logic                s2_vld_q;
  logic [FW-1:0]       s2_num_q;
  logic [TW-1:0]       s2_den_q;
  gei_pkg::frac_side_t s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_num_q  <= FW'(t_off) * FW'(gei_pkg::PERCENT);
      s2_den_q  <= s2_side.span_pos ? span[TW-1:0] : TW'(1);
      s2_side_q <= s2_side;
    end
  end

  // percent fraction
  logic                d1_vld;
  logic [FW-1:0]       d1_quo;
  logic [F1SW-1:0]     d1_side_raw;
  gei_pkg::frac_side_t d1_side;

  gei_div_pipe #(
    .NumW  (FW),
    .DenW  (TW),
    .SideW (F1SW)
  ) u_frac_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .num_i  (s2_num_q),
    .den_i  (s2_den_q),
    .side_i (s2_side_q),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side_raw)
  );

  assign d1_side = gei_pkg::frac_side_t'(d1_side_raw);

  // scale the level step by the fraction; a non-positive fraction adds nothing
  logic              s3_vld_q;
  logic [PW-1:0]     s3_prod_q;
  gei_pkg::inc_side_t s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q <= d1_side.span_pos ? PW'(d1_quo) * PW'(d1_side.abs_mag) : '0;
      s3_side_q.prev_lvl  <= d1_side.prev_lvl;
      s3_side_q.inc_neg   <= d1_side.mag_neg;
      s3_side_q.diff_neg  <= d1_side.diff_neg;
      s3_side_q.span_zero <= d1_side.span_zero;
    end
  end

  // divide by one hundred: long division in 15-bit digits, one digit per stage;
  // each digit quotient by reciprocal multiply, exact below 100 * 2^15
  function automatic logic [CW-1:0] div100(input logic [RW-1:0] v);
    logic [44:0] p;
    p = 45'(v) * 45'(RECIP100);
    div100 = p[43:29];
  endfunction

  function automatic logic [6:0] rem100(input logic [RW-1:0] v, input logic [CW-1:0] q);
    logic [RW-1:0] r;
    r = v - RW'(q) * RW'(gei_pkg::PERCENT);
    rem100 = r[6:0];
  endfunction

  logic               p0_vld_q, p1_vld_q, p2_vld_q;
  logic [RW-1:0]      p0_v, p1_v, p2_v;
  logic [RW-1:0]      p0_v_q, p1_v_q;
  logic [CW-1:0]      p0_q_q, p1_q_q, p2_q;
  logic [2*CW-1:0]    p0_lo_q;
  logic [CW-1:0]      p1_lo_q;
  logic [LW-1:0]      p2_quo_q;
  gei_pkg::inc_side_t p0_side_q, p1_side_q, p2_side_q;

  assign p0_v = RW'(s3_prod_q[PW-1:2*CW]);
  assign p1_v = {rem100(p0_v_q, p0_q_q), p0_lo_q[2*CW-1:CW]};
  assign p2_v = {rem100(p1_v_q, p1_q_q), p1_lo_q};
  assign p2_q = div100(p2_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q <= s3_vld_q;
      p1_vld_q <= p0_vld_q;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_v_q    <= p0_v;
      p0_q_q    <= div100(p0_v);
      p0_lo_q   <= s3_prod_q[2*CW-1:0];
      p0_side_q <= s3_side_q;
      p1_v_q    <= p1_v;
      p1_q_q    <= div100(p1_v);
      p1_lo_q   <= p0_lo_q[CW-1:0];
      p1_side_q <= p0_side_q;
      // only the low byte of the quotient survives the 8-bit wrap
      p2_quo_q  <= p2_q[LW-1:0];
      p2_side_q <= p1_side_q;
    end
  end

  // final step, margin and saturation into the output register
  logic [LW-1:0]        inc;
  logic signed [LW-1:0] env;
  logic signed [LW:0]   total;
  logic signed [LW-1:0] total_sat;

  always_comb begin
    inc = p2_side_q.inc_neg ? LW'(-p2_quo_q) : p2_quo_q;
    if (p2_side_q.span_zero) begin
      env = p2_side_q.prev_lvl;
    end else if (p2_side_q.diff_neg) begin
      env = LW'(p2_side_q.prev_lvl - inc);
    end else begin
      env = LW'(p2_side_q.prev_lvl + inc);
    end
    total     = (LW+1)'(env) + $signed((LW+1)'(margin_q));
    total_sat = (total > 9'sd127) ? 8'sd127 : LW'(total);
  end

  logic                 out_apply_q;
  logic signed [LW-1:0] out_env_q, out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_env_q   <= env;
      out_total_q <= total_sat;
      out_apply_q <= (total_sat != '0);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign envelope_gain_o = out_env_q;
  assign total_gain_o    = out_total_q;
  assign apply_gain_o    = out_apply_q;

endmodule

// ----- rtl/gei_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Carries a valid bit and a side vector alongside; depends on nothing.
module gei_div_pipe #(
  parameter int unsigned NumW  = 38,
  parameter int unsigned DenW  = 31,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [NumW];
  logic [DenW-1:0]  rem_q  [NumW];
  logic [NumW-1:0]  num_q  [NumW];
  logic [DenW-1:0]  den_q  [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             vld_in;
    logic [DenW-1:0]  rem_in;
    logic [NumW-1:0]  num_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_in, num_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DenW'(trial - {1'b0, den_in}) : DenW'(trial);
        num_q[k]  <= {num_in[NumW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NumW-1];
  assign quo_o  = num_q[NumW-1];
  assign side_o = side_q[NumW-1];

endmodule

// ----- sim/gei_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the gain envelope interpolator: watches the config, input and
// result channels, predicts each query's gains and compares. Depends on gei_pkg.
module gei_checker
  import gei_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_W-1:0]        cfg_index_i,
  input  logic [TIME_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    operation_i,
  input  logic [IDX_W-1:0]        mark_index_i,
  input  logic [TIME_W-1:0]       mark_time_ms_i,
  input  logic signed [LVL_W-1:0] mark_level_i,
  input  logic [TIME_W-1:0]       query_time_ms_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [LVL_W-1:0] envelope_gain_i,
  input  logic signed [LVL_W-1:0] total_gain_i,
  input  logic                    apply_gain_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct {
    logic signed [LVL_W-1:0] env;
    logic signed [LVL_W-1:0] total;
    logic                    apply;
  } gain_t;

  // shadow of the block's registers and mark table
  logic [TIME_W-1:0]       tbl_time [MAX_MARKS_DEF];
  logic signed [LVL_W-1:0] tbl_lvl  [MAX_MARKS_DEF];
  logic [CNT_W-1:0]        n_marks;
  logic [TIME_W-1:0]       clip_ms;
  logic [MRG_W-1:0]        margin;
  gain_t                   gain_q[$];

  function automatic longint wrap8(longint v);
    logic signed [7:0] b;
    b = v[7:0];
    return longint'(b);
  endfunction

  // positive levels are scaled down by the fixed divider
  function automatic longint scaled_level(logic signed [LVL_W-1:0] r);
    longint v;
    v = r;
    if (v > 0) v = v / POS_DIV_DEF;
    return v;
  endfunction

  function automatic gain_t predict_gain(logic [TIME_W-1:0] now);
    longint pt, nt, pl, nl, span, frac, diff, mag, inc, env, tot, t_now;
    int     n, i;
    bit     found;
    gain_t  g;
    t_now = now;
    pt = 0; nt = clip_ms; pl = 0; nl = 0; inc = 0; found = 0;
    n = (n_marks > MAX_MARKS_DEF) ? MAX_MARKS_DEF : n_marks;
    // slot-order scan: last mark at or before now, first mark after
    for (i = 0; i < n; i++) begin
      if (!found) begin
        if (longint'(tbl_time[i]) > t_now) begin
          nt = tbl_time[i];
          nl = scaled_level(tbl_lvl[i]);
          found = 1;
        end else begin
          pt = tbl_time[i];
          pl = scaled_level(tbl_lvl[i]);
        end
      end
    end
    span = nt - pt;
    if (span == 0) begin
      env = pl;
    end else begin
      frac = ((t_now - pt) * 100) / span;
      diff = nl - pl;
      mag  = wrap8(diff < 0 ? -diff : diff);
      if (frac > 0) inc = wrap8((mag * frac) / 100);
      env = (diff >= 0) ? wrap8(pl + inc) : wrap8(pl - inc);
    end
    tot = env + margin;
    if (tot > 127) tot = 127;
    g.env   = env[7:0];
    g.total = tot[7:0];
    g.apply = (tot != 0);
    return g;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gain_t exp_g;
    if (!rst_ni) begin
      n_marks = '0;
      clip_ms = '0;
      margin  = '0;
      gain_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (gain_q.size() == 0) begin
          report_mismatch("unexpected result, envelope", envelope_gain_i, 0);
        end else begin
          exp_g = gain_q.pop_front();
          if (envelope_gain_i !== exp_g.env)
            report_mismatch("envelope_gain", envelope_gain_i, exp_g.env);
          if (total_gain_i !== exp_g.total)
            report_mismatch("total_gain", total_gain_i, exp_g.total);
          if (apply_gain_i !== exp_g.apply)
            report_mismatch("apply_gain", apply_gain_i, exp_g.apply);
        end
      end
      // config transfer
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MARK_COUNT: n_marks = cfg_data_i[CNT_W-1:0];
          CFG_CLIP_DUR:   clip_ms = cfg_data_i;
          CFG_MARGIN:     margin  = cfg_data_i[MRG_W-1:0];
          default: ;
        endcase
      end
      // input transfer: store a mark or predict a query
      if (in_valid_i && in_ready_i) begin
        if (operation_i == OP_WRITE) begin
          tbl_time[mark_index_i] = mark_time_ms_i;
          tbl_lvl[mark_index_i]  = mark_level_i;
        end else begin
          gain_q.push_back(predict_gain(query_time_ms_i));
        end
      end
      pending_o = gain_q.size();
    end
  end

endmodule

// ----- sim/tb_gain_envelope_interpolator_core.sv -----
`timescale 1ns / 1ps
// Testbench top for gain_envelope_interpolator_core: directed and random mark
// writes and gain queries under varied idling. Depends on gei_pkg and gei_checker.
module tb_gain_envelope_interpolator_core;
  import gei_pkg::*;

  localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;
  localparam int LATENCY_WAIT = 120;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;

  logic                    clk_i, rst_ni;
  logic                    cfg_valid_i, cfg_ready_o;
  logic [CFG_W-1:0]        cfg_index_i;
  logic [TIME_W-1:0]       cfg_data_i;
  logic                    in_valid_i, in_ready_o;
  logic                    operation_i;
  logic [IDX_W-1:0]        mark_index_i;
  logic [TIME_W-1:0]       mark_time_ms_i;
  logic signed [LVL_W-1:0] mark_level_i;
  logic [TIME_W-1:0]       query_time_ms_i;
  logic                    out_valid_o, out_ready_i;
  logic signed [LVL_W-1:0] envelope_gain_o, total_gain_o;
  logic                    apply_gain_o;
  int                      fail_count, pending;

  int unsigned sender_idle_pct, recv_stall_pct, mark_step;
  bit          hold_req;
  int unsigned cycles = 0;

  gain_envelope_interpolator_core i_dut (.*);

  gei_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .mark_index_i,
    .mark_time_ms_i, .mark_level_i, .query_time_ms_i,
    .out_valid_i(out_valid_o), .out_ready_i, .envelope_gain_i(envelope_gain_o),
    .total_gain_i(total_gain_o), .apply_gain_i(apply_gain_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic sender_gap();
    bit idle;
    idle = ($urandom_range(99) < sender_idle_pct);
    if (idle) begin
      in_valid_i <= 1'b0;
      while (idle) begin
        @(posedge clk_i);
        idle = ($urandom_range(99) < sender_idle_pct);
      end
    end
  endtask

  task automatic push_item(op_e op, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] t,
                           logic signed [LVL_W-1:0] lvl, logic [TIME_W-1:0] q);
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    mark_index_i    <= idx;
    mark_time_ms_i  <= t;
    mark_level_i    <= lvl;
    query_time_ms_i <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sender_gap();
  endtask

  task automatic write_mark(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] t,
                            logic signed [LVL_W-1:0] lvl);
    push_item(OP_WRITE, idx, t, lvl, TIME_W'($urandom));
  endtask

  task automatic query(logic [TIME_W-1:0] q);
    push_item(OP_QUERY, IDX_W'($urandom), TIME_W'($urandom), LVL_W'($urandom), q);
  endtask

  // between and within phases: stop sending, then wait until all results are in
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [TIME_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle_and_configure(logic [CNT_W-1:0] n, logic [TIME_W-1:0] clip,
                                      logic [MRG_W-1:0] mrg);
    wait_results();
    repeat (LATENCY_WAIT) @(posedge clk_i);
    write_reg(CFG_MARK_COUNT, TIME_W'(n));
    write_reg(CFG_CLIP_DUR, clip);
    write_reg(CFG_MARGIN, TIME_W'(mrg));
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return TIME_W'($urandom);
    if (r < 15) return '1;
    return TIME_W'($urandom_range(17 * mark_step + 50));
  endfunction

  function automatic logic [TIME_W-1:0] slot_time(int unsigned idx);
    if ($urandom_range(99) < 10) return TIME_W'($urandom);
    return TIME_W'(idx * mark_step + $urandom_range(mark_step));
  endfunction

  task automatic random_phase(int unsigned items, bit do_hold);
    int unsigned k, r, cnt_sel;
    logic [CNT_W-1:0] n;
    logic [MRG_W-1:0] mrg;
    logic [TIME_W-1:0] clip;
    mark_step = $urandom_range(1, 300);
    cnt_sel = $urandom_range(3);
    n = (cnt_sel == 0) ? CNT_W'(16) : (cnt_sel == 1) ? CNT_W'($urandom)
                                                     : CNT_W'($urandom_range(1, 16));
    mrg  = ($urandom_range(3) == 0) ? 7'd127 : MRG_W'($urandom_range(40));
    clip = ($urandom_range(4) == 0) ? TIME_W'($urandom) : TIME_W'(17 * mark_step);
    settle_and_configure(n, clip, mrg);
    // well-formed table: marks in time order, then mostly queries
    for (k = 0; k < 16; k++) begin
      write_mark(IDX_W'(k), TIME_W'(k * mark_step + $urandom_range(mark_step / 2)),
                 LVL_W'($urandom));
    end
    for (k = 0; k < items; k++) begin
      // receiver holds off while items keep coming, so the block fills
      if (do_hold && k == 40) hold_req = 1'b1;
      if (k == items / 2) wait_results();
      r = $urandom_range(99);
      if (r < 25) begin
        r = $urandom_range(15);
        write_mark(IDX_W'(r), slot_time(r), LVL_W'($urandom));
      end else begin
        query(rand_time());
      end
    end
  endtask

  initial begin
    int unsigned ph;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; operation_i = OP_WRITE; mark_index_i = '0;
    mark_time_ms_i = '0; mark_level_i = '0; query_time_ms_i = '0;
    sender_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill every slot, levels at the extremes
    write_reg(CFG_SPARE, '1);
    write_reg(CFG_MARK_COUNT, 31'd4);
    write_reg(CFG_CLIP_DUR, 31'd1000);
    write_reg(CFG_MARGIN, 31'd0);
    write_mark(4'd0, 31'd100, -8'sd128);
    write_mark(4'd1, 31'd200, 8'sd127);
    write_mark(4'd2, 31'd200, -8'sd1);
    write_mark(4'd3, 31'd500, 8'sd1);
    for (int i = 4; i < 16; i++) write_mark(IDX_W'(i), '1, 8'sd0);
    query(31'd0);       // before the first mark
    query(31'd50);
    query(31'd100);     // exactly on a mark
    query(31'd150);
    query(31'd200);     // on two marks at the same time
    query(31'd350);
    query(31'd800);     // past the last mark, towards clip end
    query('1);          // clip end before the query
    settle_and_configure(5'd0, 31'd0, 7'd127);   // no marks, zero span
    query(31'd0);
    query(31'd77);
    settle_and_configure(5'd31, '1, 7'd100);     // count above table size
    query(31'd150);
    query('1);
    query(31'h2AAAAAAA);

    // random phases under different idling
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      random_phase(220, ph == 0);
    end

    wait_results();
    repeat (LATENCY_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
